/* rtl/bstl_pkg.sv */
// Shared types, constants, micro-program and single-precision arithmetic for the STL reader.
package bstl_pkg;

    localparam int unsigned HEADER_BYTES  = 80;
    localparam int unsigned COUNT_BYTES   = 4;
    localparam int unsigned PAYLOAD_BYTES = 48;
    localparam int unsigned RECORD_BYTES  = 50;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    localparam logic [31:0] FP_QNAN   = 32'h7FC0_0000;
    localparam logic [31:0] FP_THRESH = 32'h322B_CC77;

    localparam logic [4:0] LAST_WORD = 5'd11;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_CMP
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] a;
        logic [4:0] b;
        logic [4:0] d;
    } prog_t;

    typedef struct packed {
        logic       cnt_shift;
        logic       word_shift;
        logic       wr_word;
        logic [3:0] word_idx;
        logic       idx_clr;
        logic       idx_inc;
        logic       rd_en;
        logic [4:0] rd_a;
        logic [4:0] rd_b;
        logic       ex_en;
        op_t        op;
        logic       wr_res;
        logic [4:0] wr_addr;
        logic       load_tri;
        logic       load_err;
        logic [1:0] err_code;
    } dp_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic last;
        logic out_free;
    } dp_sts_t;

    // Scratch words 0..11 hold the record, 12..24 hold intermediate results.
    function automatic prog_t prog_fetch(input logic [4:0] step);
        prog_t p;
        begin
            case (step)
                5'd0:    p = '{OP_SUB, 5'd6,  5'd3,  5'd12};
                5'd1:    p = '{OP_SUB, 5'd7,  5'd4,  5'd13};
                5'd2:    p = '{OP_SUB, 5'd8,  5'd5,  5'd14};
                5'd3:    p = '{OP_SUB, 5'd9,  5'd3,  5'd15};
                5'd4:    p = '{OP_SUB, 5'd10, 5'd4,  5'd16};
                5'd5:    p = '{OP_SUB, 5'd11, 5'd5,  5'd17};
                5'd6:    p = '{OP_MUL, 5'd13, 5'd17, 5'd18};
                5'd7:    p = '{OP_MUL, 5'd14, 5'd16, 5'd19};
                5'd8:    p = '{OP_SUB, 5'd18, 5'd19, 5'd20};
                5'd9:    p = '{OP_MUL, 5'd14, 5'd15, 5'd18};
                5'd10:   p = '{OP_MUL, 5'd12, 5'd17, 5'd19};
                5'd11:   p = '{OP_SUB, 5'd18, 5'd19, 5'd21};
                5'd12:   p = '{OP_MUL, 5'd12, 5'd16, 5'd18};
                5'd13:   p = '{OP_MUL, 5'd13, 5'd15, 5'd19};
                5'd14:   p = '{OP_SUB, 5'd18, 5'd19, 5'd22};
                5'd15:   p = '{OP_MUL, 5'd0,  5'd0,  5'd18};
                5'd16:   p = '{OP_MUL, 5'd1,  5'd1,  5'd19};
                5'd17:   p = '{OP_ADD, 5'd18, 5'd19, 5'd23};
                5'd18:   p = '{OP_MUL, 5'd2,  5'd2,  5'd18};
                5'd19:   p = '{OP_ADD, 5'd23, 5'd18, 5'd23};
                5'd20:   p = '{OP_MUL, 5'd20, 5'd0,  5'd18};
                5'd21:   p = '{OP_MUL, 5'd21, 5'd1,  5'd19};
                5'd22:   p = '{OP_ADD, 5'd18, 5'd19, 5'd24};
                5'd23:   p = '{OP_MUL, 5'd22, 5'd2,  5'd18};
                5'd24:   p = '{OP_ADD, 5'd24, 5'd18, 5'd24};
                default: p = '{OP_CMP, 5'd23, 5'd24, 5'd0};
            endcase
            return p;
        end
    endfunction

    // Rounds to nearest even. m has its leading one at bit 26, bit 0 is sticky.
    function automatic logic [31:0] fp_pack(input logic s, input logic signed [11:0] e,
                                            input logic [26:0] m);
        logic [26:0]        mm;
        logic signed [11:0] ee;
        logic [11:0]        nsh;
        logic [4:0]         sh;
        logic               lost;
        logic               up;
        logic [30:0]        mag;
        begin
            mm = m;
            ee = e;
            if (ee >= 12'sd255)
            begin
                return {s, 8'hFF, 23'd0};
            end
            if (ee <= 12'sd0)
            begin
                nsh = 12'(12'sd1 - ee);
                if (nsh >= 12'd27)
                begin
                    mm = {26'd0, |m};
                end
                else
                begin
                    sh   = nsh[4:0];
                    lost = |(m << (5'd27 - sh));
                    mm   = (m >> sh) | {26'd0, lost};
                end
                ee = 12'sd1;
            end
            up  = mm[2] & (mm[1] | mm[0] | mm[3]);
            mag = {ee[7:0] - 8'd1, 23'd0} + {7'd0, mm[26:3]} + {30'd0, up};
            return {s, mag};
        end
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               s;
        logic [7:0]         ea;
        logic [7:0]         eb;
        logic               a_nan;
        logic               b_nan;
        logic               a_inf;
        logic               b_inf;
        logic               a_zero;
        logic               b_zero;
        logic [23:0]        ma;
        logic [23:0]        mb;
        logic [47:0]        p;
        logic [47:0]        pn;
        logic [5:0]         lz;
        logic signed [11:0] e;
        begin
            s      = a[31] ^ b[31];
            ea     = a[30:23];
            eb     = b[30:23];
            a_nan  = (ea == 8'hFF) && (a[22:0] != 23'd0);
            b_nan  = (eb == 8'hFF) && (b[22:0] != 23'd0);
            a_inf  = (ea == 8'hFF) && (a[22:0] == 23'd0);
            b_inf  = (eb == 8'hFF) && (b[22:0] == 23'd0);
            a_zero = (a[30:0] == 31'd0);
            b_zero = (b[30:0] == 31'd0);
            if (a_nan || b_nan)
            begin
                return FP_QNAN;
            end
            if (a_inf || b_inf)
            begin
                return (a_zero || b_zero) ? FP_QNAN : {s, 8'hFF, 23'd0};
            end
            if (a_zero || b_zero)
            begin
                return {s, 31'd0};
            end
            ma = {ea != 8'd0, a[22:0]};
            mb = {eb != 8'd0, b[22:0]};
            if (ea == 8'd0)
            begin
                ea = 8'd1;
            end
            if (eb == 8'd0)
            begin
                eb = 8'd1;
            end
            p  = {24'd0, ma} * {24'd0, mb};
            lz = 6'd0;
            for (int i = 0; i < 48; i++)
            begin
                if (p[i])
                begin
                    lz = 6'(47 - i);
                end
            end
            pn = p << lz;
            e  = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126 - $signed({6'd0, lz});
            return fp_pack(s, e, {pn[47:22], |pn[21:0]});
        end
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic               a_nan;
        logic               b_nan;
        logic               a_inf;
        logic               b_inf;
        logic [31:0]        big;
        logic [31:0]        sml;
        logic [7:0]         eb;
        logic [7:0]         es;
        logic [7:0]         d;
        logic [26:0]        mbig;
        logic [26:0]        msml;
        logic [26:0]        al;
        logic               lost;
        logic [27:0]        sum;
        logic [4:0]         lz;
        logic [26:0]        m;
        logic signed [11:0] e;
        begin
            a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
            b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
            a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
            b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
            if (a_nan || b_nan)
            begin
                return FP_QNAN;
            end
            if (a_inf && b_inf && (a[31] != b[31]))
            begin
                return FP_QNAN;
            end
            if (a_inf)
            begin
                return a;
            end
            if (b_inf)
            begin
                return b;
            end
            if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
            begin
                return {a[31] & b[31], 31'd0};
            end
            if (a[30:0] >= b[30:0])
            begin
                big = a;
                sml = b;
            end
            else
            begin
                big = b;
                sml = a;
            end
            eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
            es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
            mbig = {big[30:23] != 8'd0, big[22:0], 3'd0};
            msml = {sml[30:23] != 8'd0, sml[22:0], 3'd0};
            d    = eb - es;
            if (d >= 8'd27)
            begin
                al = {26'd0, |msml};
            end
            else
            begin
                lost = |(msml << (5'd27 - d[4:0]));
                al   = (msml >> d[4:0]) | {26'd0, lost};
            end
            if (big[31] != sml[31])
            begin
                sum = {1'b0, mbig} - {1'b0, al};
            end
            else
            begin
                sum = {1'b0, mbig} + {1'b0, al};
            end
            if (sum == 28'd0)
            begin
                return 32'd0;
            end
            e = $signed({4'd0, eb});
            if (sum[27])
            begin
                m = {sum[27:2], sum[1] | sum[0]};
                e = e + 12'sd1;
            end
            else
            begin
                lz = 5'd0;
                for (int i = 0; i < 27; i++)
                begin
                    if (sum[i])
                    begin
                        lz = 5'(26 - i);
                    end
                end
                m = sum[26:0] << lz;
                e = e - $signed({7'd0, lz});
            end
            return fp_pack(big[31], e, m);
        end
    endfunction

    function automatic logic fp_is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic fp_gt(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ka;
        logic [31:0] kb;
        begin
            if (fp_is_nan(a) || fp_is_nan(b))
            begin
                return 1'b0;
            end
            if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
            begin
                return 1'b0;
            end
            ka = a[31] ? ~a : (a | 32'h8000_0000);
            kb = b[31] ? ~b : (b | 32'h8000_0000);
            return ka > kb;
        end
    endfunction

    function automatic logic fp_below_zero(input logic [31:0] a);
        return !fp_is_nan(a) && a[31] && (a[30:0] != 31'd0);
    endfunction

endpackage

/* rtl/bstl_byte_if.sv */
// Byte stream channel: valid/ready handshake carrying one stream byte or the end mark.
interface bstl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink (input valid, input data_byte, input stream_end, output ready);
endinterface

/* rtl/bstl_tri_if.sv */
// Triangle result channel: valid/ready handshake carrying one triangle or error item.
interface bstl_tri_if;
    logic        valid;
    logic        ready;
    logic [31:0] vertex0_x;
    logic [31:0] vertex0_y;
    logic [31:0] vertex0_z;
    logic [31:0] vertex1_x;
    logic [31:0] vertex1_y;
    logic [31:0] vertex1_z;
    logic [31:0] vertex2_x;
    logic [31:0] vertex2_y;
    logic [31:0] vertex2_z;
    logic        swap_winding;
    logic        last_triangle;
    logic [1:0]  status;

    modport source (output valid, output vertex0_x, output vertex0_y, output vertex0_z,
                    output vertex1_x, output vertex1_y, output vertex1_z,
                    output vertex2_x, output vertex2_y, output vertex2_z,
                    output swap_winding, output last_triangle, output status,
                    input ready);
    modport sink (input valid, input vertex0_x, input vertex0_y, input vertex0_z,
                  input vertex1_x, input vertex1_y, input vertex1_z,
                  input vertex2_x, input vertex2_y, input vertex2_z,
                  input swap_winding, input last_triangle, input status,
                  output ready);
endinterface

/* rtl/bstl_dp.sv */
// Datapath: count and word assembly, scratch memory, shared float unit and result register.
module bstl_dp
    import bstl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        data_byte,
    input  dp_cmd_t           cmd,
    output dp_sts_t           sts,
    bstl_tri_if.source        tri_ch
);

    logic [31:0] total_reg;
    logic [31:0] index_reg;
    logic [31:0] word_reg;
    logic [31:0] word_full;
    logic [31:0] vtx_reg [0:8];
    logic [31:0] mem [0:31];
    logic [31:0] ra_reg;
    logic [31:0] rb_reg;
    logic [31:0] res_reg;
    logic        swap_reg;
    logic        we;
    logic [4:0]  waddr;
    logic [31:0] wdata;
    logic [31:0] rb_op;
    logic [3:0]  vtx_idx;

    logic        out_valid_reg;
    logic [31:0] out_vtx_reg [0:8];
    logic        out_swap_reg;
    logic        out_last_reg;
    logic [1:0]  out_status_reg;

    assign word_full = {data_byte, word_reg[31:8]};
    assign vtx_idx   = cmd.word_idx - 4'd3;
    assign we        = cmd.wr_word | cmd.wr_res;
    assign waddr     = cmd.wr_word ? {1'b0, cmd.word_idx} : cmd.wr_addr;
    assign wdata     = cmd.wr_word ? word_full : res_reg;
    assign rb_op     = (cmd.op == OP_SUB) ? {~rb_reg[31], rb_reg[30:0]} : rb_reg;

    assign sts.count_zero = ({data_byte, total_reg[31:8]} == 32'd0);
    assign sts.last       = (index_reg == (total_reg - 32'd1));
    assign sts.out_free   = !out_valid_reg || tri_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            index_reg <= '0;
        end
        else
        begin
            if (cmd.cnt_shift)
            begin
                total_reg <= {data_byte, total_reg[31:8]};
            end
            if (cmd.idx_clr)
            begin
                index_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                index_reg <= index_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.word_shift)
        begin
            word_reg <= word_full;
        end
        if (cmd.wr_word && (cmd.word_idx >= 4'd3))
        begin
            vtx_reg[vtx_idx] <= word_full;
        end
        if (cmd.ex_en)
        begin
            if (cmd.op == OP_MUL)
            begin
                res_reg <= fp_mul(ra_reg, rb_reg);
            end
            else if (cmd.op == OP_CMP)
            begin
                swap_reg <= fp_gt(ra_reg, FP_THRESH) && fp_below_zero(rb_reg);
            end
            else
            begin
                res_reg <= fp_add(ra_reg, rb_op);
            end
        end
    end

    // Scratch memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en)
        begin
            ra_reg <= mem[cmd.rd_a];
            rb_reg <= mem[cmd.rd_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_tri || cmd.load_err)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (tri_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_tri)
        begin
            for (int i = 0; i < 9; i++)
            begin
                out_vtx_reg[i] <= vtx_reg[i];
            end
            out_swap_reg   <= swap_reg;
            out_last_reg   <= sts.last;
            out_status_reg <= ST_OK;
        end
        else if (cmd.load_err)
        begin
            for (int i = 0; i < 9; i++)
            begin
                out_vtx_reg[i] <= 32'd0;
            end
            out_swap_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
            out_status_reg <= cmd.err_code;
        end
    end

    assign tri_ch.valid         = out_valid_reg;
    assign tri_ch.vertex0_x     = out_vtx_reg[0];
    assign tri_ch.vertex0_y     = out_vtx_reg[1];
    assign tri_ch.vertex0_z     = out_vtx_reg[2];
    assign tri_ch.vertex1_x     = out_vtx_reg[3];
    assign tri_ch.vertex1_y     = out_vtx_reg[4];
    assign tri_ch.vertex1_z     = out_vtx_reg[5];
    assign tri_ch.vertex2_x     = out_vtx_reg[6];
    assign tri_ch.vertex2_y     = out_vtx_reg[7];
    assign tri_ch.vertex2_z     = out_vtx_reg[8];
    assign tri_ch.swap_winding  = out_swap_reg;
    assign tri_ch.last_triangle = out_last_reg;
    assign tri_ch.status        = out_status_reg;

endmodule

/* rtl/bstl_ctrl.sv */
// Controller: stream parse phases and the sequencer that steps the winding micro-program.
module bstl_ctrl
    import bstl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    stream_end,
    output logic    in_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_HEADER,
        S_COUNT,
        S_RECORDS,
        S_RD,
        S_EX,
        S_WR,
        S_EMIT,
        S_DONE
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [6:0] off_reg;
    logic [6:0] off_next;
    logic [4:0] step_reg;
    logic [4:0] step_next;
    prog_t      prog;
    logic       parsing;
    logic       accept;

    assign prog     = prog_fetch(step_reg);
    assign parsing  = (state_reg == S_HEADER) || (state_reg == S_COUNT) ||
                      (state_reg == S_RECORDS);
    // An end mark needs room in the result register for its error item.
    // Once the stream is closed every further item is taken and dropped.
    assign in_ready = (state_reg == S_DONE) || (parsing && (!stream_end || sts.out_free));
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        cmd.op     = OP_ADD;
        state_next = state_reg;
        off_next   = off_reg;
        step_next  = step_reg;
        case (state_reg)
            S_HEADER:
            begin
                if (accept)
                begin
                    if (stream_end)
                    begin
                        cmd.load_err = 1'b1;
                        cmd.err_code = ST_EMPTY;
                        state_next   = S_DONE;
                    end
                    else if (off_reg == 7'(HEADER_BYTES - 1))
                    begin
                        off_next   = '0;
                        state_next = S_COUNT;
                    end
                    else
                    begin
                        off_next = off_reg + 7'd1;
                    end
                end
            end
            S_COUNT:
            begin
                if (accept)
                begin
                    if (stream_end)
                    begin
                        cmd.load_err = 1'b1;
                        cmd.err_code = ST_EMPTY;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        cmd.cnt_shift = 1'b1;
                        if (off_reg == 7'(COUNT_BYTES - 1))
                        begin
                            off_next = '0;
                            if (sts.count_zero)
                            begin
                                cmd.load_err = 1'b1;
                                cmd.err_code = ST_EMPTY;
                                state_next   = S_DONE;
                            end
                            else
                            begin
                                cmd.idx_clr = 1'b1;
                                state_next  = S_RECORDS;
                            end
                        end
                        else
                        begin
                            off_next = off_reg + 7'd1;
                        end
                    end
                end
            end
            S_RECORDS:
            begin
                if (accept)
                begin
                    if (stream_end)
                    begin
                        cmd.load_err = 1'b1;
                        cmd.err_code = ST_TRUNC;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        if (off_reg < 7'(PAYLOAD_BYTES))
                        begin
                            cmd.word_shift = 1'b1;
                            cmd.word_idx   = off_reg[5:2];
                            cmd.wr_word    = (off_reg[1:0] == 2'd3);
                        end
                        if (off_reg == 7'(RECORD_BYTES - 1))
                        begin
                            off_next   = '0;
                            step_next  = '0;
                            state_next = S_RD;
                        end
                        else
                        begin
                            off_next = off_reg + 7'd1;
                        end
                    end
                end
            end
            S_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_a   = prog.a;
                cmd.rd_b   = prog.b;
                state_next = S_EX;
            end
            S_EX:
            begin
                cmd.ex_en  = 1'b1;
                cmd.op     = prog.op;
                state_next = (prog.op == OP_CMP) ? S_EMIT : S_WR;
            end
            S_WR:
            begin
                cmd.wr_res  = 1'b1;
                cmd.wr_addr = prog.d;
                step_next   = step_reg + 5'd1;
                state_next  = S_RD;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_tri = 1'b1;
                    if (sts.last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_RECORDS;
                    end
                end
            end
            default:
            begin
                state_next = S_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HEADER;
            off_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            off_reg   <= off_next;
            step_reg  <= step_next;
        end
    end

`ifndef SYNTH
    a_load_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_tri || cmd.load_err) |-> sts.out_free)
        else $error("result loaded while the result register is still held");

    a_word_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_word |-> ({1'b0, cmd.word_idx} <= LAST_WORD))
        else $error("record word index beyond the record");

    a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> (state_reg == S_DONE))
        else $error("block left the done phase without reset");

    a_no_input_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        (!parsing && (state_reg != S_DONE)) |-> !in_ready)
        else $error("input taken while the winding test runs");
`endif

endmodule

/* rtl/binary_stl_parse_winding_fix.sv */
// Top level of the binary STL reader with triangle winding check.
//
//   Channel   Role   Payload                                        Accepted when
//   byte_ch   sink   data_byte[7:0], stream_end                     valid && ready
//   tri_ch    source vertex0_x..vertex2_z[31:0], swap_winding,      valid && ready
//                    last_triangle, status[1:0]
//
// Header and count bytes are taken at one per cycle, as are the 50 bytes of each record.
// After the last byte of a record the shared float add/multiply unit runs a 26-step
// program over the scratch memory (each step a read, an execute and a write, the final
// compare only a read and an execute), and input pauses until the triangle is loaded.
// Reset is asynchronous and active low; once the done phase is reached bytes are dropped.
// A held result only stalls an end-of-stream item and the hand-over of the next triangle.
module binary_stl_parse_winding_fix
    import bstl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bstl_byte_if.sink  byte_ch,
    bstl_tri_if.source tri_ch
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // The controller owns the parse phases and the program sequencer.
    bstl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (byte_ch.valid),
        .stream_end (byte_ch.stream_end),
        .in_ready   (byte_ch.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // The datapath assembles words, evaluates the cross and dot products and holds the item.
    bstl_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (byte_ch.data_byte),
        .cmd       (cmd),
        .sts       (sts),
        .tri_ch    (tri_ch)
    );

endmodule
